@@ sv/costas_array_cost_evaluator_assert.svh @@
// assertion macros for the costas cost evaluator checker
`ifndef COSTAS_ARRAY_COST_EVALUATOR_ASSERT_SVH
`define COSTAS_ARRAY_COST_EVALUATOR_ASSERT_SVH
// implication check under reset
`define CACE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication check under reset
`define CACE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ sv/cace_pkg.sv @@
// shared types and constants for the costas cost evaluator
package cace_pkg;
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_EVAL = 2'd1;
	localparam logic [1:0] OP_TRIAL = 2'd2;
	localparam logic [1:0] OP_COMMIT = 2'd3;
	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;
	localparam int MAX_SIZE = 32;
	localparam int SLOT_COUNT = 64;
	localparam int TOTAL_W = 24;
	localparam int ERR_W = 20;
	// result item fields
	typedef struct packed {
		logic [TOTAL_W-1:0] amount;
		logic [4:0] var_index;
		logic kind;
	} result_t;
endpackage

@@ sv/costas_array_cost_evaluator.sv @@
// costas array cost evaluator top level
//  channel  | dir | payload
//  s_axis   | in  | tdata: op, position, second_position, value
//  m_axis   | out | tdata: kind, var_index, amount; tlast
//  cfg      | in  | active_size
// each difference pair takes two store reads, a count update and an advance; in a
// recording op a repeated pair adds charge steps for its own pair, and at its first
// repeat also for the first pair. each distance starts with a clear of all 64 slots;
// a recording op first clears all 32 error store entries and ends with one error
// transfer per variable; a write is stored on accept; a trial swap is then swapped back.
// reset clears control state only; a stalled m_axis holds the sequencer,
// s_axis is not ready until done.
module costas_array_cost_evaluator (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // op[1:0] position[6:2] second_position[11:7] value[17:12]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // kind[0] var_index[5:1] amount[29:6]
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [5:0] cfg_data
);
	import cace_pkg::*;
	localparam int IW = $clog2(MAX_SIZE);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SWAPA = 4'd1, ST_SWAPB = 4'd2,
		ST_CLR = 4'd3, ST_RDA = 4'd4, ST_RDB = 4'd5, ST_CNT = 4'd6,
		ST_CH1 = 4'd7, ST_CH2 = 4'd8, ST_OUT = 4'd9, ST_ERRRD = 4'd10,
		ST_ERROUT = 4'd11, ST_ECLR = 4'd12, ST_UNSW = 4'd13;
	logic [3:0] state_q;

	logic [5:0] size_q;
	logic [5:0] sol_mem [MAX_SIZE];
	logic [5:0] cnt_mem [SLOT_COUNT];
	logic [4:0] fp_mem [SLOT_COUNT];
	logic [ERR_W-1:0] err_mem [MAX_SIZE];

	logic [1:0] op_q;
	logic [4:0] pa_q, pb_q;
	logic swap_ok_q;
	logic undo_q;
	logic [5:0] va_q, vb_q;
	logic [5:0] d_q, i_q, half_q, slot_q, cnt_q, n_q;
	logic [5:0] fpos_q;
	logic [TOTAL_W-1:0] w_q, total_q;
	logic [ERR_W-1:0] rd_err_q;
	logic [IW:0] k_q;
	logic [1:0] sub_q;
	logic [5:0] sol_rd_q;
	logic [5:0] clr_q;
	logic record_q;
	logic outv_q, outl_q;
	result_t out_q;

	// clamp size
	logic [5:0] n_c;
	always_comb begin
		n_c = size_q;
		if (size_q < 6'd3) n_c = 6'd3;
		if ({1'b0, size_q} > 7'(MAX_SIZE)) n_c = 6'(MAX_SIZE);
	end

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !outv_q;
	assign m_axis_tvalid = outv_q;
	assign m_axis_tlast = outl_q;
	assign m_axis_tdata = {2'b00, out_q};

	// charge address and shared weight add
	logic [IW:0] ch_k;
	logic [ERR_W-1:0] ch_sum;
	assign ch_k = (state_q == ST_CH1) ? (IW+1)'(i_q) : (IW+1)'(fpos_q);
	assign ch_sum = rd_err_q + w_q[ERR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 6'd32;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready &&
			s_axis_tdata[1:0] == OP_WRITE && {1'b0, s_axis_tdata[6:2]} < 6'(MAX_SIZE))
			sol_mem[IW'(s_axis_tdata[6:2])] <= s_axis_tdata[17:12];
		if ((state_q == ST_SWAPB || state_q == ST_UNSW) && swap_ok_q) begin
			sol_mem[IW'(pa_q)] <= vb_q;
		end
		if (state_q == ST_CLR) cnt_mem[clr_q] <= 6'd0;
		if (state_q == ST_CNT && sub_q == 2'd1) begin
			cnt_mem[slot_q] <= cnt_q;
			if (cnt_q == 6'd1) fp_mem[slot_q] <= i_q[4:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			outv_q <= 1'b0;
			outl_q <= 1'b0;
			sub_q <= 2'd0;
			undo_q <= 1'b0;
		end else begin
			if (outv_q && m_axis_tready) outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q <= s_axis_tdata[1:0];
					pa_q <= s_axis_tdata[6:2];
					pb_q <= s_axis_tdata[11:7];
					swap_ok_q <= s_axis_tdata[1] &&
						{1'b0, s_axis_tdata[6:2]} < 6'(MAX_SIZE) &&
						{1'b0, s_axis_tdata[11:7]} < 6'(MAX_SIZE);
					record_q <= s_axis_tdata[1:0] != OP_TRIAL;
					n_q <= n_c;
					half_q <= (n_c - 6'd1) >> 1;
					total_q <= '0;
					d_q <= 6'd1;
					clr_q <= 6'd0;
					k_q <= '0;
					sub_q <= 2'd0;
					undo_q <= 1'b0;
					if (s_axis_tdata[1:0] != OP_WRITE)
						state_q <= (s_axis_tdata[1:0] == OP_TRIAL) ? ST_SWAPA : ST_ECLR;
				end
				ST_ECLR: begin
					// clear error store one entry a cycle
					err_mem[k_q[IW-1:0]] <= '0;
					if (k_q == (IW+1)'(MAX_SIZE - 1)) begin
						k_q <= '0;
						state_q <= ST_SWAPA;
					end else k_q <= k_q + 1'b1;
				end
				ST_SWAPA: begin
					// two reads of the swap pair
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd0) sol_rd_q <= sol_mem[IW'(pa_q)];
					else if (sub_q == 2'd1) begin
						va_q <= sol_rd_q;
						sol_rd_q <= sol_mem[IW'(pb_q)];
					end else begin
						vb_q <= sol_rd_q;
						sub_q <= 2'd0;
						state_q <= ST_SWAPB;
					end
				end
				ST_SWAPB: begin
					pa_q <= pb_q;
					pb_q <= pa_q;
					vb_q <= va_q;
					state_q <= ST_UNSW;
				end
				ST_UNSW: begin
					pa_q <= pb_q;
					pb_q <= pa_q;
					if (undo_q) begin
						undo_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						w_q <= TOTAL_W'(n_q) * TOTAL_W'(n_q) - TOTAL_W'(d_q) * TOTAL_W'(d_q);
						state_q <= (half_q == 6'd0) ? ST_OUT : ST_CLR;
					end
				end
				ST_CLR: begin
					if (clr_q == 6'(SLOT_COUNT - 1)) begin
						clr_q <= 6'd0;
						i_q <= d_q;
						state_q <= ST_RDA;
					end else clr_q <= clr_q + 6'd1;
				end
				ST_RDA: begin
					va_q <= sol_mem[IW'(i_q - d_q)];
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					slot_q <= va_q + n_q - sol_mem[IW'(i_q)];
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					cnt_q <= cnt_mem[slot_q] + 6'd1;
					fpos_q <= {1'b0, fp_mem[slot_q]};
					sub_q <= 2'd1;
					if (sub_q == 2'd1) begin
						sub_q <= 2'd0;
						if (cnt_q > 6'd1) total_q <= total_q + w_q;
						state_q <= (record_q && cnt_q > 6'd1) ? ST_CH1 : ST_CH2;
						k_q <= (cnt_q == 6'd2) ? '0 : (IW+1)'(2);
					end
				end
				ST_CH1: begin
					// charge pairs: k_q 0/1 first pair, 2/3 current pair
					if (k_q[1] == 1'b0) begin
						if (k_q[0] == 1'b0) rd_err_q <= err_mem[IW'(fpos_q)];
						else begin
							err_mem[IW'(fpos_q)] <= ch_sum;
							fpos_q <= fpos_q - d_q;
							if (fpos_q - d_q == fpos_q) k_q <= (IW+1)'(2);
						end
						if (k_q[0] == 1'b1 && sub_q == 2'd0) begin
							sub_q <= 2'd1;
							k_q <= '0;
						end else if (k_q[0] == 1'b1) begin
							sub_q <= 2'd0;
							k_q <= (IW+1)'(2);
						end else k_q <= k_q + 1'b1;
					end else begin
						if (k_q[0] == 1'b0) rd_err_q <= err_mem[IW'(ch_k)];
						else begin
							err_mem[IW'(i_q)] <= ch_sum;
							if (sub_q == 2'd0) begin
								sub_q <= 2'd1;
								i_q <= i_q - d_q;
							end else begin
								sub_q <= 2'd0;
								i_q <= i_q + d_q;
								state_q <= ST_CH2;
							end
						end
						k_q <= {k_q[IW:1], ~k_q[0]};
					end
				end
				ST_CH2: begin
					if (i_q + 6'd1 == n_q) begin
						if (d_q == half_q) state_q <= ST_OUT;
						else begin
							d_q <= d_q + 6'd1;
							w_q <= TOTAL_W'(n_q) * TOTAL_W'(n_q)
								- TOTAL_W'(d_q + 6'd1) * TOTAL_W'(d_q + 6'd1);
							state_q <= ST_CLR;
						end
					end else begin
						i_q <= i_q + 6'd1;
						state_q <= ST_RDA;
					end
				end
				ST_OUT: if (!outv_q || m_axis_tready) begin
					outv_q <= 1'b1;
					out_q <= '{amount: total_q, var_index: 5'd0, kind: KIND_TOTAL};
					outl_q <= !record_q;
					k_q <= '0;
					// a trial swap is undone by swapping the pair again
					if (op_q == OP_TRIAL && swap_ok_q) begin
						undo_q <= 1'b1;
						state_q <= ST_SWAPA;
					end else state_q <= record_q ? ST_ERRRD : ST_IDLE;
				end
				ST_ERRRD: begin
					rd_err_q <= err_mem[k_q[IW-1:0]];
					state_q <= ST_ERROUT;
				end
				ST_ERROUT: if (!outv_q || m_axis_tready) begin
					outv_q <= 1'b1;
					out_q <= '{amount: TOTAL_W'(rd_err_q), var_index: 5'(k_q),
						kind: KIND_ERROR};
					outl_q <= (k_q + 1'b1) == (IW+1)'(n_q);
					if ((k_q + 1'b1) == (IW+1)'(n_q)) state_q <= ST_IDLE;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_ERRRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ sv/cace_checker.sv @@
// port-level checker for the costas cost evaluator
`include "costas_array_cost_evaluator_assert.svh"
module cace_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic [31:0] m_axis_tdata
);
	`CACE_ASSERT_NEXT(a_busy_after_eval, s_axis_tvalid && s_axis_tready && m_axis_tvalid, !s_axis_tready)
	`CACE_ASSERT_IMP(a_no_accept_while_out, m_axis_tvalid, !s_axis_tready)
	`CACE_ASSERT_IMP(a_total_idx_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[5:1] == 5'd0)
	`CACE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind costas_array_cost_evaluator cace_checker u_cace_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast),
	.m_axis_tdata(m_axis_tdata)
);

@@ tb/sv/tb_costas_array_cost_evaluator.sv @@
// self-checking testbench for the costas array cost evaluator
module tb_costas_array_cost_evaluator;
	import cace_pkg::*;

	localparam int MAX_N = 32;

	// one input item of the directed table
	typedef struct {
		logic [1:0] op;
		logic [4:0] pos_a;
		logic [4:0] pos_b;
		logic [5:0] val;
		bit has_total;
		logic [23:0] total;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [5:0] cfg_data;

	// predictor state
	logic [5:0] perm [MAX_N];
	logic [19:0] var_err [MAX_N];
	bit written [MAX_N];
	logic [5:0] size_reg;
	// expected results, oldest first
	logic [30:0] pending_results [$];
	int errors;
	bit hold_rx;
	bit rx_done;

	costas_array_cost_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("tb_costas_array_cost_evaluator: done, errors");
		$finish;
	end

	function automatic int clamp_size();
		int n;
		n = size_reg;
		if (n < 3) n = 3;
		if (n > MAX_N) n = MAX_N;
		return n;
	endfunction

	// add a weight to both variables of one difference pair
	function automatic void add_weight(int k, int d, int w);
		if (k < MAX_N && k >= d) begin
			var_err[k] = var_err[k] + w[19:0];
			var_err[k-d] = var_err[k-d] + w[19:0];
		end
	endfunction

	// difference-triangle cost of the current permutation
	function automatic logic [23:0] triangle_cost(bit record);
		int n, half, w, slot, cnt;
		logic [5:0] counts [64];
		logic [4:0] first [64];
		logic [23:0] total;
		n = clamp_size();
		half = (n - 1) / 2;
		total = '0;
		foreach (first[s]) first[s] = '0;
		if (record) foreach (var_err[k]) var_err[k] = '0;
		for (int d = 1; d <= half; d++) begin
			w = n * n - d * d;
			foreach (counts[s]) counts[s] = '0;
			for (int i = d; i < n; i++) begin
				slot = (int'(perm[i-d]) + 64 + n - int'(perm[i])) & 63;
				cnt = (int'(counts[slot]) + 1) & 63;
				counts[slot] = cnt[5:0];
				if (record) begin
					if (cnt == 1) first[slot] = i[4:0];
					else begin
						if (cnt == 2) add_weight(first[slot], d, w);
						add_weight(i, d, w);
					end
				end
				if (cnt > 1) total = total + w[23:0];
			end
		end
		return total;
	endfunction

	function automatic void exchange(logic [4:0] a, logic [4:0] b);
		logic [5:0] t;
		t = perm[a];
		perm[a] = perm[b];
		perm[b] = t;
	endfunction

	function automatic logic [23:0] typed_total_sel(bit has, logic [23:0] t, logic [23:0] p);
		return has ? t : p;
	endfunction

	// random swap index among written entries, else the fallback
	function automatic logic [4:0] pick_pos(logic [4:0] fallback);
		logic [4:0] p;
		p = 5'($urandom);
		return written[p] ? p : fallback;
	endfunction

	// work out and queue the results of one accepted item
	function automatic void predict_item(logic [1:0] op, logic [4:0] a, logic [4:0] b,
			logic [5:0] v, bit has_total, logic [23:0] typed_total);
		logic [23:0] total;
		int n;
		n = clamp_size();
		case (op)
			OP_WRITE: begin
				perm[a] = v;
				written[a] = 1'b1;
				return;
			end
			OP_TRIAL: begin
				exchange(a, b);
				total = triangle_cost(1'b0);
				exchange(a, b);
			end
			OP_EVAL: total = triangle_cost(1'b1);
			default: begin
				exchange(a, b);
				total = triangle_cost(1'b1);
			end
		endcase
		if (has_total && total != typed_total) begin
			$display("%0t table total expected %0d model %0d", $time, typed_total, total);
			errors++;
		end
		pending_results.push_back({op == OP_TRIAL, typed_total_sel(has_total, typed_total,
			total), 5'd0, KIND_TOTAL});
		if (op != OP_TRIAL)
			for (int i = 0; i < n; i++)
				pending_results.push_back({i == n - 1, 4'd0, var_err[i], i[4:0], KIND_ERROR});
	endfunction

	// one input transfer after a random gap; valid stays up until the next gap
	task automatic send_item(logic [1:0] op, logic [4:0] a, logic [4:0] b, logic [5:0] v,
			bit has_total, logic [23:0] typed_total, bit gaps);
		int gap;
		gap = gaps ? int'($urandom_range(0, 14)) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {6'd0, v, b, a, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(op, a, b, v, has_total, typed_total);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_size(logic [5:0] n);
		cfg_data <= n;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		size_reg = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// fill entries 0..n-1 with a random permutation of 1..n
	task automatic load_perm(int n);
		int vals [$];
		for (int i = 1; i <= n; i++) vals.push_back(i);
		vals.shuffle();
		for (int i = 0; i < n; i++)
			send_item(OP_WRITE, i[4:0], 5'($urandom), vals[i][5:0], 1'b0, 24'd0, 1'b1);
	endtask

	// receiver: random stalls
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		while (!rx_done) begin
			@(negedge clk);
			if (hold_rx) m_axis_tready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else m_axis_tready <= 1'b1;
		end
	end

	// result checks: kind/idx/amount/last
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				logic [30:0] want;
				want = pending_results.pop_front();
				if (want[0] !== m_axis_tdata[0] || want[5:1] !== m_axis_tdata[5:1]
						|| want[29:6] !== m_axis_tdata[29:6] || want[30] !== m_axis_tlast) begin
					$display("%0t expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$time, want[0], want[5:1], want[29:6], want[30],
						m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[29:6],
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		row_t dir [$];
		int n, kind;
		logic [4:0] a, b;
		errors = 0;
		hold_rx = 0;
		rx_done = 0;
		size_reg = 6'd32;
		foreach (perm[i]) perm[i] = '0;
		foreach (var_err[i]) var_err[i] = '0;
		foreach (written[i]) written[i] = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: n = 3 identity (difference -1 repeats, weight 9-1 = 8)
		write_size(6'd3);
		dir.push_back('{OP_WRITE, 5'd0, 5'd0, 6'd1, 1'b0, 24'd0});
		dir.push_back('{OP_WRITE, 5'd1, 5'd0, 6'd2, 1'b0, 24'd0});
		dir.push_back('{OP_WRITE, 5'd2, 5'd0, 6'd3, 1'b0, 24'd0});
		dir.push_back('{OP_EVAL, 5'd0, 5'd0, 6'd0, 1'b1, 24'd8});
		dir.push_back('{OP_TRIAL, 5'd0, 5'd2, 6'd0, 1'b1, 24'd8});
		dir.push_back('{OP_TRIAL, 5'd0, 5'd1, 6'd0, 1'b1, 24'd0});
		dir.push_back('{OP_TRIAL, 5'd1, 5'd1, 6'd0, 1'b1, 24'd8});
		dir.push_back('{OP_COMMIT, 5'd0, 5'd1, 6'd0, 1'b1, 24'd0});
		dir.push_back('{OP_COMMIT, 5'd2, 5'd2, 6'd0, 1'b0, 24'd0});
		// out-of-range values alias (63 and 0 extremes)
		dir.push_back('{OP_WRITE, 5'd2, 5'd0, 6'd63, 1'b0, 24'd0});
		dir.push_back('{OP_WRITE, 5'd1, 5'd0, 6'd0, 1'b0, 24'd0});
		dir.push_back('{OP_EVAL, 5'd31, 5'd31, 6'd63, 1'b0, 24'd0});
		dir.push_back('{OP_TRIAL, 5'd2, 5'd0, 6'd0, 1'b0, 24'd0});
		foreach (dir[r])
			send_item(dir[r].op, dir[r].pos_a, dir[r].pos_b, dir[r].val,
				dir[r].has_total, dir[r].total, 1'b1);
		wait_drained();

		// configuration sweep incl. clamped values, random item mix per phase
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_size(6'd0);
				1: write_size(6'd63);
				2: write_size(6'd32);
				3: write_size(6'd4);
				default: write_size(6'($urandom_range(3, 12)));
			endcase
			n = clamp_size();
			load_perm(n);
			if (ph == 1) begin
				// long receiver hold while the sender keeps offering
				hold_rx = 1;
				fork
					begin
						repeat (3000) @(negedge clk);
						hold_rx = 0;
					end
					for (int k = 0; k < 4; k++) send_item(OP_TRIAL, 5'($urandom_range(0, 31)),
						5'($urandom_range(0, 31)), 6'($urandom), 1'b0, 24'd0, 1'b0);
				join
			end
			for (int k = 0; k < (ph < 3 ? 4 : 8); k++) begin
				kind = $urandom_range(0, 9);
				a = 5'($urandom_range(0, n - 1));
				b = 5'($urandom_range(0, n - 1));
				if (kind < 2)
					send_item(OP_WRITE, a, 5'($urandom), 6'($urandom), 1'b0, 24'd0, 1'b1);
				else if (kind < 3)
					send_item(OP_EVAL, 5'($urandom), 5'($urandom), 6'($urandom),
						1'b0, 24'd0, 1'b1);
				else if (kind < 7)
					send_item(OP_TRIAL, $urandom_range(0, 4) == 0 ? pick_pos(a) : a, b,
						6'($urandom), 1'b0, 24'd0, 1'b1);
				else
					send_item(OP_COMMIT, a, $urandom_range(0, 4) == 0 ? pick_pos(b) : b,
						6'($urandom), 1'b0, 24'd0, 1'b1);
			end
			// sender waits for every result before the next phase
			wait_drained();
		end

		wait_drained();
		rx_done = 1;
		if (errors == 0)
			$display("tb_costas_array_cost_evaluator: done, clean");
		else
			$display("tb_costas_array_cost_evaluator: done, errors");
		$finish;
	end
endmodule
